// ===== rtl/cbc_pkg.sv =====
// shared types and constants of the cartridge bank controller
package cbc_pkg;

   localparam int AddrWidth      = 16;
   localparam int ByteWidth      = 8;
   localparam int OffsetWidth    = 21;
   localparam int RomBytesWidth  = 24;
   localparam int RamBytesWidth  = 18;
   localparam int RomBankWidth   = 7;
   localparam int RamBankWidth   = 2;
   localparam int RomPageBits    = 14;
   localparam int RamPageBits    = 13;
   localparam int CsrAddrWidth   = 4;
   localparam int CsrDataWidth   = 32;

   localparam logic [3:0]              RamEnableKey = 4'hA;
   localparam logic [RomBankWidth-1:0] RomBankReset = 7'd1;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_MBC1 = 2'd1,
      KIND_MBC3 = 2'd2,
      KIND_RSVD = 2'd3
   } ctrl_kind_type;

   typedef enum logic [1:0] {
      REQ_ROM_RD = 2'd0,
      REQ_REG_WR = 2'd1,
      REQ_RAM_RD = 2'd2,
      REQ_RAM_WR = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ACC_NONE   = 2'd0,
      ACC_ROM_RD = 2'd1,
      ACC_RAM_RD = 2'd2,
      ACC_RAM_WR = 2'd3
   } access_type;

   typedef enum logic [1:0] {
      CSR_KIND      = 2'd0,
      CSR_ROM_BYTES = 2'd1,
      CSR_RAM_BYTES = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_reg_type;

endpackage

// ===== rtl/cbc_req_if.sv =====
// request channel: bus access beats into the controller
interface cbc_req_if;
   import cbc_pkg::*;

   logic                 valid;
   logic                 ready;
   req_kind_type         req_type;
   logic [AddrWidth-1:0] addr;
   logic [ByteWidth-1:0] value;

   modport source (output valid, output req_type, output addr, output value, input ready);
   modport sink   (input valid, input req_type, input addr, input value, output ready);
endinterface

// ===== rtl/cbc_rsp_if.sv =====
// response channel: external memory access beats out of the controller
interface cbc_rsp_if;
   import cbc_pkg::*;

   logic                   valid;
   logic                   ready;
   access_type             access;
   logic [OffsetWidth-1:0] mem_offset;
   logic [ByteWidth-1:0]   write_byte;

   modport source (output valid, output access, output mem_offset, output write_byte,
                   input ready);
   modport sink   (input valid, input access, input mem_offset, input write_byte,
                   output ready);
endinterface

// ===== rtl/cartridge_bank_controller_core.sv =====
// cartridge bank controller: bank registers, address mapping, csr port
// a response beat is valid in the cycle after its request beat is accepted
// throughput: one request beat per cycle; a single output register holds the response
// and a new request is taken whenever that register is empty or being drained
// reset: synchronous, active high; rom bank 1, ram bank 0, ram disabled, mode 0,
// all csr registers 0, no response pending
module cartridge_bank_controller_core (
   input  logic                               clock,
   input  logic                               reset,
   cbc_req_if.sink                            req,
   cbc_rsp_if.source                          rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cbc_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [cbc_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [cbc_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready
);
   import cbc_pkg::*;

   ctrl_kind_type            kind_ff,      kind_in;
   logic [RomBytesWidth-1:0] rom_bytes_ff, rom_bytes_in;
   logic [RamBytesWidth-1:0] ram_bytes_ff, ram_bytes_in;
   logic [RomBankWidth-1:0]  rom_bank_ff,  rom_bank_in;
   logic [RamBankWidth-1:0]  ram_bank_ff,  ram_bank_in;
   logic                     ram_en_ff,    ram_en_in;
   logic                     mode_ff,      mode_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   access_type               access_ff,    access_in;
   logic [OffsetWidth-1:0]   offset_ff,    offset_in;
   logic [ByteWidth-1:0]     wbyte_ff,     wbyte_in;

   logic                     req_fire;
   logic                     csr_write;
   csr_reg_type              csr_index;
   logic                     banked;
   logic [OffsetWidth-1:0]   rom_cand;
   logic [RamPageBits+RamBankWidth-1:0] ram_cand;
   logic [6:0]               bank_sel;

   assign req.ready    = !rsp_valid_ff || rsp.ready;
   assign req_fire     = req.valid && req.ready;
   assign csr_pready   = 1'b1;
   assign csr_write    = csr_psel && csr_penable && csr_pwrite;
   assign csr_index    = csr_reg_type'(csr_paddr[3:2]);

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.access     = access_ff;
   assign rsp.mem_offset = offset_ff;
   assign rsp.write_byte = wbyte_ff;

   // csr read and write
   always_comb begin
      kind_in      = kind_ff;
      rom_bytes_in = rom_bytes_ff;
      ram_bytes_in = ram_bytes_ff;
      csr_prdata   = '0;
      case (csr_index)
         CSR_KIND: begin
            csr_prdata = CsrDataWidth'(kind_ff);
            if (csr_write) kind_in = ctrl_kind_type'(csr_pwdata[1:0]);
         end
         CSR_ROM_BYTES: begin
            csr_prdata = CsrDataWidth'(rom_bytes_ff);
            if (csr_write) rom_bytes_in = csr_pwdata[RomBytesWidth-1:0];
         end
         CSR_RAM_BYTES: begin
            csr_prdata = CsrDataWidth'(ram_bytes_ff);
            if (csr_write) ram_bytes_in = csr_pwdata[RamBytesWidth-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // address mapping and bank register updates
   always_comb begin
      rom_bank_in  = rom_bank_ff;
      ram_bank_in  = ram_bank_ff;
      ram_en_in    = ram_en_ff;
      mode_in      = mode_ff;
      access_in    = ACC_NONE;
      offset_in    = '0;
      wbyte_in     = '0;
      banked       = (kind_ff == KIND_MBC1) || (kind_ff == KIND_MBC3);
      rom_cand     = req.addr[14] ? {rom_bank_ff, req.addr[RomPageBits-1:0]}
                                  : OffsetWidth'(req.addr[RomPageBits-1:0]);
      ram_cand     = {ram_bank_ff, req.addr[RamPageBits-1:0]};
      bank_sel     = (kind_ff == KIND_MBC1) ? {2'b00, req.value[4:0]} : req.value[6:0];
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      if (req_fire) begin
         rsp_valid_in = 1'b1;
         case (req.req_type)
            REQ_ROM_RD: begin
               if (!req.addr[15] && (RomBytesWidth'(rom_cand) < rom_bytes_ff)) begin
                  access_in = ACC_ROM_RD;
                  offset_in = rom_cand;
               end
            end
            REQ_REG_WR: begin
               if (banked && !req.addr[15]) begin
                  case (req.addr[14:13])
                     2'b00: ram_en_in = (req.value[3:0] == RamEnableKey);
                     2'b01: begin
                        if (bank_sel == '0) begin
                           bank_sel = 7'd1;
                        end
                        if (kind_ff == KIND_MBC1) begin
                           rom_bank_in = {rom_bank_ff[6:5], bank_sel[4:0]};
                        end else begin
                           rom_bank_in = bank_sel;
                        end
                     end
                     2'b10: ram_bank_in = req.value[RamBankWidth-1:0];
                     default: begin
                        if (kind_ff == KIND_MBC1) mode_in = req.value[0];
                     end
                  endcase
               end
            end
            default: begin
               if (ram_en_ff && (ram_bytes_ff != '0) && (req.addr[15:13] == 3'b101)
                   && (RamBytesWidth'(ram_cand) < ram_bytes_ff)) begin
                  offset_in = OffsetWidth'(ram_cand);
                  if (req.req_type == REQ_RAM_RD) begin
                     access_in = ACC_RAM_RD;
                  end else begin
                     access_in = ACC_RAM_WR;
                     wbyte_in  = req.value;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= KIND_NONE;
         rom_bytes_ff <= '0;
         ram_bytes_ff <= '0;
         rom_bank_ff  <= RomBankReset;
         ram_bank_ff  <= '0;
         ram_en_ff    <= 1'b0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kind_ff      <= kind_in;
         rom_bytes_ff <= rom_bytes_in;
         ram_bytes_ff <= ram_bytes_in;
         rom_bank_ff  <= rom_bank_in;
         ram_bank_ff  <= ram_bank_in;
         ram_en_ff    <= ram_en_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         access_ff <= access_in;
         offset_ff <= offset_in;
         wbyte_ff  <= wbyte_in;
      end
   end

   // rom bank never drops to zero
   a_rom_bank_nonzero: assert property (@(posedge clock) disable iff (reset)
      rom_bank_ff != '0) else $error("rom bank register is zero");

   // a register write beat never produces a memory access
   a_reg_wr_no_access: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req.req_type == REQ_REG_WR) |=> rsp.valid && (rsp.access == ACC_NONE))
      else $error("register write produced an access");

   // write data only travels with a ram write
   a_wbyte_only_on_write: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.access != ACC_RAM_WR) |-> (rsp.write_byte == '0))
      else $error("write byte set without ram write");

   // bank and enable state moves only on an accepted register write
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && (req.req_type == REQ_REG_WR)) |=>
         $stable(rom_bank_ff) && $stable(ram_bank_ff) && $stable(ram_en_ff)
         && $stable(mode_ff))
      else $error("bank state changed without a register write");

   // a held response stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.access)
         && $stable(rsp.mem_offset))
      else $error("pending response lost or changed");

endmodule
